[src/rbd_pkg.sv]
package rbd_pkg;

  // Default number of words in the store.
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Word width of the stored values.
  localparam int unsigned WORD_W = 32;

  // Value returned by a pop from an empty queue.
  localparam logic [WORD_W-1:0] INT_MIN = 32'h8000_0000;

  // Operation requested by an input beat.
  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } opcode_t;

  // Outcome reported with each result beat.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL_REJ  = 2'd1,
    ST_EMPTY_REJ = 2'd2
  } status_t;

  // Per-operation result information passed from the pointer unit.
  typedef struct packed {
    logic    pop_ok;
    status_t status;
    logic    full;
    logic    empty;
  } rbd_info_t;

endpackage

[src/rbd_ptr.sv]
module rbd_ptr
  import rbd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  opcode_t       opcode,
  output logic          mem_wr,
  output logic          mem_rd,
  output logic [AW-1:0] mem_addr,
  output rbd_info_t     info
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] front, front_next;
  logic [AW-1:0] back, back_next;
  logic          full, full_next;
  logic          empty, empty_next;

  // Pointer arithmetic, modulo DEPTH.
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST : p - AW'(1);
  endfunction

  // Decide the memory access and the new pointers and flags.
  always_comb begin
    front_next = front;
    back_next  = back;
    full_next  = full;
    empty_next = empty;
    mem_wr     = 1'b0;
    mem_rd     = 1'b0;
    mem_addr   = back;
    info       = '{pop_ok: 1'b0, status: ST_DONE, full: full, empty: empty};
    unique case (opcode)
      OP_PUSH_BACK: begin
        if (full) begin
          info.status = ST_FULL_REJ;
        end else begin
          mem_wr     = 1'b1;
          mem_addr   = back;
          back_next  = ptr_inc(back);
          empty_next = 1'b0;
          full_next  = (front == ptr_inc(back));
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          info.status = ST_FULL_REJ;
        end else begin
          mem_wr     = 1'b1;
          mem_addr   = ptr_dec(front);
          front_next = ptr_dec(front);
          empty_next = 1'b0;
          full_next  = (ptr_dec(front) == back);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          info.status = ST_EMPTY_REJ;
        end else begin
          mem_rd      = 1'b1;
          mem_addr    = front;
          info.pop_ok = 1'b1;
          front_next  = ptr_inc(front);
          full_next   = 1'b0;
          empty_next  = (ptr_inc(front) == back);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          info.status = ST_EMPTY_REJ;
        end else begin
          mem_rd      = 1'b1;
          mem_addr    = ptr_dec(back);
          info.pop_ok = 1'b1;
          back_next   = ptr_dec(back);
          full_next   = 1'b0;
          empty_next  = (front == ptr_dec(back));
        end
      end
      default: begin
        info.status = ST_DONE;
      end
    endcase
    info.full  = full_next;
    info.empty = empty_next;
  end

  // Pointer and flag registers advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      full  <= 1'b0;
      empty <= 1'b1;
    end else if (accept) begin
      front <= front_next;
      back  <= back_next;
      full  <= full_next;
      empty <= empty_next;
    end
  end

endmodule

[src/ring_buffer_deque.sv]
// Channel  Dir  tdata           tuser                              Use
// s_*      in   push_value      opcode                             one operation per beat
// m_*      out  pop_value       status, is_full, is_empty          one result per operation
//
// One operation per clock cycle is sustained while m_tready holds; a result
// passes through the registered read of the word store and the pending
// stage, then through the output register.
// Reset clears the pointers and flags; the store is not cleared.
// A stalled result holds in the output register, one more in the pending stage,
// and input is refused only while both are occupied.
module ring_buffer_deque
  import rbd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] push_value
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] pop_value
  output logic [3:0]  m_tuser    // [1:0] status, [2] is_full, [3] is_empty
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic              s_beat;
  logic              mem_wr;
  logic              mem_rd;
  logic [AW-1:0]     mem_addr;
  rbd_info_t         info;
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic              pend_valid;
  rbd_info_t         pend_info;
  logic              move;
  logic [WORD_W-1:0] pop_value;

  assign s_beat   = s_tvalid && s_tready;
  assign move     = pend_valid && (!m_tvalid || m_tready);
  assign s_tready = !pend_valid || move;

  rbd_ptr #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ptr (
    .clk      (clk),
    .rst      (rst),
    .accept   (s_beat),
    .opcode   (opcode_t'(s_tuser)),
    .mem_wr   (mem_wr),
    .mem_rd   (mem_rd),
    .mem_addr (mem_addr),
    .info     (info)
  );

  // Word store with registered read data.
  always_ff @(posedge clk) begin
    if (s_beat && mem_wr) begin
      mem[mem_addr] <= s_tdata;
    end
    if (s_beat && mem_rd) begin
      rdata <= mem[mem_addr];
    end
  end

  // Pending stage waits for the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s_beat) begin
      pend_valid <= 1'b1;
    end else if (move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      pend_info <= info;
    end
  end

  // Select the returned word for the result beat.
  always_comb begin
    if (pend_info.pop_ok) begin
      pop_value = rdata;
    end else if (pend_info.status == ST_EMPTY_REJ) begin
      pop_value = INT_MIN;
    end else begin
      pop_value = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      m_tdata <= pop_value;
      m_tuser <= {pend_info.empty, pend_info.full, pend_info.status};
    end
  end

endmodule
